// File: rtl/dlts_pkg.sv
// Package for the delta-list timer scheduler: sizes, request and status codes.
// Used by rtl/delta_list_timer_scheduler.sv; depends on nothing.
`default_nettype none
package dlts_pkg;
    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int PTR_W     = $clog2(NUM_SLOTS + 1);
    localparam int MAX_OUT   = 16;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NUM_SLOTS);

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_ADD  = 2'd1,
        REQ_DEL  = 2'd2,
        REQ_DISP = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_ADDED = 3'd0,
        ST_FULL  = 3'd1,
        ST_DISP  = 3'd2,
        ST_NONE  = 3'd3,
        ST_ACK   = 3'd4
    } t_status;
endpackage
`default_nettype wire

// File: rtl/delta_list_timer_scheduler.sv
// Delta-list timer scheduler top level: slot memory and list-walking sequencer.
// Depends on rtl/dlts_pkg.sv.
//
// Input channel s_axis: tdata carries req_type, task_handle, delay, period and
// slot_id. A tick decrements a nonzero head delta; an add takes the lowest
// free slot and links it in by cumulative delay; a delete unlinks a slot and
// folds its delta into the successor; a dispatch pops every zero-delta head
// (up to 16) and reports each, re-adding periodic tasks.
// Output channel m_axis: tdata carries status, slot_id_out and task_handle_out;
// tlast marks the final result of a request.
// One request is handled at a time. The slot records sit in a memory with one
// read port and a registered read, so a list walk spends a read state and a
// check state on each visited entry. A tick reads and rewrites the head; a
// delete walks to the slot, then relinks its predecessor and successor; an add
// walks, then writes the new slot, its predecessor and its successor. A dispatch
// checks and emits each popped task, re-adds periodic ones by a walk, then ends.
// Each result sits in an output register; the sequencer waits while the
// receiver stalls and resumes when the result is taken. Reset empties the list
// and frees every slot at once; no clearing pass is needed.
`default_nettype none
module delta_list_timer_scheduler (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // req_type[1:0], task_handle[17:2], delay[49:18], period[81:50],
    // slot_id[89:82], zero fill [95:90]
    input  wire logic [95:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[2:0], slot_id_out[6:3], task_handle_out[22:7], zero fill [23]
    output logic [23:0]       m_axis_tdata,
    output logic              m_axis_tlast
);
    localparam int SW = dlts_pkg::SLOT_W;
    localparam int PW = dlts_pkg::PTR_W;
    localparam int CW = dlts_pkg::CNT_W;

    typedef struct packed {
        logic [15:0]   handle;
        logic [31:0]   delta;
        logic [31:0]   period;
        logic [PW-1:0] next;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE, S_TICK_RD, S_TICK_WR, S_ADD_START, S_ADD_RD, S_ADD_CHK,
        S_LINK_SLOT, S_LINK_PREV, S_LINK_CURR, S_DEL_RD, S_DEL_CHK,
        S_DEL_PREV, S_DEL_NX, S_DISP_RD, S_DISP_CHK, S_DISP_EMIT,
        S_DISP_END, S_OUT
    } t_state;

    t_entry            mem [dlts_pkg::NUM_SLOTS];
    t_entry            r_rd_data;
    logic              mem_we;
    logic [SW-1:0]     mem_wa, mem_ra;
    t_entry            mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

    t_state                         r_state;
    logic [dlts_pkg::NUM_SLOTS-1:0] r_used;
    logic [PW-1:0]                  r_head;
    logic [15:0]                    r_handle;
    logic [31:0]                    r_acc, r_period;
    logic [PW-1:0]                  r_id, r_prev, r_curr, r_nx;
    logic [SW-1:0]                  r_slot, r_pop_slot;
    logic [31:0]                    r_del_delta;
    logic [SW:0]                    r_guard;
    logic [CW-1:0]                  r_cnt;
    logic                           r_disp_link;
    t_entry                         r_pentry, r_centry;
    logic                           r_pend_valid;
    logic [SW-1:0]                  r_pend_slot;
    logic [15:0]                    r_pend_handle;
    dlts_pkg::t_status              r_res_st;
    logic [3:0]                     r_res_slot;
    logic                           r_ovalid, r_olast;
    dlts_pkg::t_status              r_ost;
    logic [3:0]                     r_oslot;
    logic [15:0]                    r_ohandle;

    logic [PW-1:0] free_slot;
    logic [PW-1:0] in_id;

    always_comb begin
        free_slot = dlts_pkg::NIL;
        for (int i = dlts_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = PW'(i);
            end
        end
    end

    assign in_id = (s_axis_tdata[89:82] < 8'(dlts_pkg::NUM_SLOTS))
                   ? PW'(s_axis_tdata[89:82]) : dlts_pkg::NIL;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {1'b0, r_ohandle, r_oslot, r_ost};

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_curr[SW-1:0];
        mem_wd = r_centry;
        mem_ra = r_curr[SW-1:0];
        unique case (r_state)
            S_TICK_RD, S_DISP_RD: mem_ra = r_head[SW-1:0];
            S_TICK_WR: begin
                mem_we = (r_rd_data.delta != 32'd0);
                mem_wa = r_head[SW-1:0];
                mem_wd = r_rd_data;
                mem_wd.delta = r_rd_data.delta - 32'd1;
            end
            S_LINK_SLOT: begin
                mem_we = 1'b1;
                mem_wa = r_slot;
                mem_wd = '{handle: r_handle, delta: r_acc,
                           period: r_period, next: r_curr};
            end
            S_LINK_PREV: begin
                mem_we = (r_prev != dlts_pkg::NIL);
                mem_wa = r_prev[SW-1:0];
                mem_wd = r_pentry;
                mem_wd.next = PW'(r_slot);
            end
            S_LINK_CURR: begin
                mem_we = (r_curr != dlts_pkg::NIL);
                mem_wa = r_curr[SW-1:0];
                mem_wd = r_centry;
                mem_wd.delta = r_centry.delta - r_acc;
            end
            S_DEL_PREV: begin
                mem_we = (r_prev != dlts_pkg::NIL);
                mem_wa = r_prev[SW-1:0];
                mem_wd = r_pentry;
                mem_wd.next = r_nx;
                mem_ra = r_nx[SW-1:0];
            end
            S_DEL_NX: begin
                mem_we = (r_nx != dlts_pkg::NIL);
                mem_wa = r_nx[SW-1:0];
                mem_wd = r_rd_data;
                mem_wd.delta = r_rd_data.delta + r_del_delta;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_head       <= dlts_pkg::NIL;
            r_ovalid     <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_handle     <= s_axis_tdata[17:2];
                        r_acc        <= s_axis_tdata[49:18];
                        r_period     <= s_axis_tdata[81:50];
                        r_id         <= in_id;
                        r_cnt        <= '0;
                        r_disp_link  <= 1'b0;
                        r_pend_valid <= 1'b0;
                        r_res_slot   <= '0;
                        unique case (dlts_pkg::t_req'(s_axis_tdata[1:0]))
                            dlts_pkg::REQ_TICK: begin
                                r_res_st <= dlts_pkg::ST_ACK;
                                r_state  <= (r_head == dlts_pkg::NIL) ? S_OUT : S_TICK_RD;
                            end
                            dlts_pkg::REQ_ADD: begin
                                r_state <= S_ADD_START;
                            end
                            dlts_pkg::REQ_DEL: begin
                                r_res_st <= dlts_pkg::ST_ACK;
                                r_prev   <= dlts_pkg::NIL;
                                r_curr   <= r_head;
                                r_guard  <= '0;
                                r_state  <= (in_id == dlts_pkg::NIL || !r_used[in_id[SW-1:0]])
                                            ? S_OUT : S_DEL_RD;
                            end
                            default: begin
                                r_state <= S_DISP_RD;
                            end
                        endcase
                    end
                end
                S_TICK_RD: r_state <= S_TICK_WR;
                S_TICK_WR: r_state <= S_OUT;
                S_ADD_START: begin
                    if (free_slot == dlts_pkg::NIL) begin
                        r_res_st   <= dlts_pkg::ST_FULL;
                        r_res_slot <= '0;
                        r_state    <= r_disp_link ? S_DISP_RD : S_OUT;
                    end else begin
                        r_slot     <= free_slot[SW-1:0];
                        r_used[free_slot[SW-1:0]] <= 1'b1;
                        r_prev     <= dlts_pkg::NIL;
                        r_curr     <= r_head;
                        r_guard    <= '0;
                        r_res_st   <= dlts_pkg::ST_ADDED;
                        r_res_slot <= 4'(free_slot);
                        r_state    <= S_ADD_RD;
                    end
                end
                S_ADD_RD: r_state <= (r_curr == dlts_pkg::NIL) ? S_LINK_SLOT : S_ADD_CHK;
                S_ADD_CHK: begin
                    if (r_acc >= r_rd_data.delta
                        && r_guard < (SW+1)'(dlts_pkg::NUM_SLOTS)) begin
                        r_acc    <= r_acc - r_rd_data.delta;
                        r_prev   <= r_curr;
                        r_pentry <= r_rd_data;
                        r_curr   <= r_rd_data.next;
                        r_guard  <= r_guard + (SW+1)'(1);
                        r_state  <= S_ADD_RD;
                    end else begin
                        r_centry <= r_rd_data;
                        r_state  <= S_LINK_SLOT;
                    end
                end
                S_LINK_SLOT: begin
                    if (r_prev == dlts_pkg::NIL) r_head <= PW'(r_slot);
                    r_state <= S_LINK_PREV;
                end
                S_LINK_PREV: r_state <= S_LINK_CURR;
                S_LINK_CURR: r_state <= r_disp_link ? S_DISP_RD : S_OUT;
                S_DEL_RD: begin
                    if (r_curr == dlts_pkg::NIL
                        || (r_guard >= (SW+1)'(dlts_pkg::NUM_SLOTS) && r_curr != r_id)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DEL_CHK;
                    end
                end
                S_DEL_CHK: begin
                    if (r_curr == r_id) begin
                        r_nx        <= r_rd_data.next;
                        r_del_delta <= r_rd_data.delta;
                        r_state     <= S_DEL_PREV;
                    end else begin
                        r_prev   <= r_curr;
                        r_pentry <= r_rd_data;
                        r_curr   <= r_rd_data.next;
                        r_guard  <= r_guard + (SW+1)'(1);
                        r_state  <= S_DEL_RD;
                    end
                end
                S_DEL_PREV: begin
                    if (r_prev == dlts_pkg::NIL) r_head <= r_nx;
                    r_used[r_id[SW-1:0]] <= 1'b0;
                    r_state <= S_DEL_NX;
                end
                S_DEL_NX: r_state <= S_OUT;
                S_DISP_RD: begin
                    r_state <= (r_cnt < CW'(dlts_pkg::MAX_OUT) && r_head != dlts_pkg::NIL)
                               ? S_DISP_CHK : S_DISP_END;
                end
                S_DISP_CHK: begin
                    if (r_rd_data.delta != 32'd0) begin
                        r_state <= S_DISP_END;
                    end else begin
                        r_head      <= r_rd_data.next;
                        r_used[r_head[SW-1:0]] <= 1'b0;
                        r_cnt       <= r_cnt + CW'(1);
                        r_pop_slot  <= r_head[SW-1:0];
                        r_handle    <= r_rd_data.handle;
                        r_period    <= r_rd_data.period;
                        r_acc       <= r_rd_data.period;
                        r_disp_link <= 1'b1;
                        r_state     <= S_DISP_EMIT;
                    end
                end
                S_DISP_EMIT: begin
                    if (!r_pend_valid || !r_ovalid) begin
                        if (r_pend_valid) begin
                            r_ovalid  <= 1'b1;
                            r_ost     <= dlts_pkg::ST_DISP;
                            r_oslot   <= 4'(r_pend_slot);
                            r_ohandle <= r_pend_handle;
                            r_olast   <= 1'b0;
                        end
                        r_pend_valid  <= 1'b1;
                        r_pend_slot   <= r_pop_slot;
                        r_pend_handle <= r_handle;
                        r_state <= (r_period != 32'd0) ? S_ADD_START : S_DISP_RD;
                    end
                end
                S_DISP_END: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_olast  <= 1'b1;
                        if (r_pend_valid) begin
                            r_ost     <= dlts_pkg::ST_DISP;
                            r_oslot   <= 4'(r_pend_slot);
                            r_ohandle <= r_pend_handle;
                        end else begin
                            r_ost     <= dlts_pkg::ST_NONE;
                            r_oslot   <= '0;
                            r_ohandle <= '0;
                        end
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid  <= 1'b1;
                        r_ost     <= r_res_st;
                        r_oslot   <= r_res_slot;
                        r_ohandle <= '0;
                        r_olast   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: tb/sv/tb_delta_list_timer_scheduler.sv
// Testbench for the delta-list timer scheduler: drives requests on the input
// stream, predicts every result with its own model of the delta list and
// checks each output transaction. Depends on rtl/dlts_pkg.sv and the top level.
`default_nettype none
module tb_delta_list_timer_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        dlts_pkg::t_status status;
        logic [3:0]        slot;
        logic [15:0]       handle;
        logic              last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    bit          used_q [dlts_pkg::NUM_SLOTS];
    logic [15:0] handle_q [dlts_pkg::NUM_SLOTS];
    logic [31:0] delta_q [dlts_pkg::NUM_SLOTS];
    logic [31:0] period_q [dlts_pkg::NUM_SLOTS];
    int          next_q [dlts_pkg::NUM_SLOTS];
    int          head_q;

    t_result     due_results [$];
    int          n_errors = 0;
    int          long_hold = 0;
    int          burst_left = 0;
    int          ready_phase = 0;

    always #2 i_clk = ~i_clk;

    delta_list_timer_scheduler u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    function automatic void link_slot(int s, logic [31:0] d);
        int prev;
        int curr;
        int guard;
        logic [31:0] acc;
        prev = dlts_pkg::NUM_SLOTS;
        curr = head_q;
        guard = 0;
        acc = d;
        while (curr < dlts_pkg::NUM_SLOTS && guard < dlts_pkg::NUM_SLOTS
               && acc >= delta_q[curr]) begin
            acc -= delta_q[curr];
            prev = curr;
            curr = next_q[curr];
            guard++;
        end
        delta_q[s] = acc;
        next_q[s] = curr;
        if (prev >= dlts_pkg::NUM_SLOTS) head_q = s;
        else next_q[prev] = s;
        if (curr < dlts_pkg::NUM_SLOTS) delta_q[curr] -= acc;
    endfunction

    function automatic int take_slot(logic [15:0] h, logic [31:0] d, logic [31:0] p);
        int s;
        for (s = 0; s < dlts_pkg::NUM_SLOTS; s++) if (!used_q[s]) break;
        if (s >= dlts_pkg::NUM_SLOTS) return dlts_pkg::NUM_SLOTS;
        used_q[s] = 1'b1;
        handle_q[s] = h;
        period_q[s] = p;
        link_slot(s, d);
        return s;
    endfunction

    function automatic void free_slot(int s);
        used_q[s] = 1'b0;
        delta_q[s] = '0;
        period_q[s] = '0;
        handle_q[s] = '0;
        next_q[s] = dlts_pkg::NUM_SLOTS;
    endfunction

    function automatic void unlink_slot(int id);
        int prev;
        int curr;
        int guard;
        int nx;
        prev = dlts_pkg::NUM_SLOTS;
        curr = head_q;
        guard = 0;
        if (id >= dlts_pkg::NUM_SLOTS || !used_q[id]) return;
        while (curr < dlts_pkg::NUM_SLOTS && guard < dlts_pkg::NUM_SLOTS && curr != id) begin
            prev = curr;
            curr = next_q[curr];
            guard++;
        end
        if (curr != id) return;
        nx = next_q[id];
        if (prev >= dlts_pkg::NUM_SLOTS) head_q = nx;
        else next_q[prev] = nx;
        if (nx < dlts_pkg::NUM_SLOTS) delta_q[nx] += delta_q[id];
        free_slot(id);
    endfunction

    function automatic void push_result(dlts_pkg::t_status st, int s, logic [15:0] h,
                                        bit l);
        t_result r;
        r.status = st;
        r.slot = s[3:0];
        r.handle = h;
        r.last = l;
        due_results.push_back(r);
    endfunction

    function automatic void predict_request(dlts_pkg::t_req req, logic [15:0] h,
                                            logic [31:0] d, logic [31:0] p,
                                            logic [7:0] sid);
        int s;
        int k;
        logic [15:0] hh;
        logic [31:0] pp;
        case (req)
            dlts_pkg::REQ_TICK: begin
                if (head_q < dlts_pkg::NUM_SLOTS && delta_q[head_q] > 0) delta_q[head_q]--;
                push_result(dlts_pkg::ST_ACK, 0, '0, 1'b1);
            end
            dlts_pkg::REQ_ADD: begin
                s = take_slot(h, d, p);
                if (s >= dlts_pkg::NUM_SLOTS) push_result(dlts_pkg::ST_FULL, 0, '0, 1'b1);
                else push_result(dlts_pkg::ST_ADDED, s, '0, 1'b1);
            end
            dlts_pkg::REQ_DEL: begin
                unlink_slot(sid);
                push_result(dlts_pkg::ST_ACK, 0, '0, 1'b1);
            end
            default: begin
                k = 0;
                while (k < dlts_pkg::MAX_OUT && head_q < dlts_pkg::NUM_SLOTS
                       && delta_q[head_q] == 0) begin
                    s = head_q;
                    hh = handle_q[s];
                    pp = period_q[s];
                    head_q = next_q[s];
                    free_slot(s);
                    if (pp > 0) void'(take_slot(hh, pp, pp));
                    push_result(dlts_pkg::ST_DISP, s, hh, 1'b0);
                    k++;
                end
                if (k == 0) push_result(dlts_pkg::ST_NONE, 0, '0, 1'b1);
                else due_results[$].last = 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    task automatic send_request(dlts_pkg::t_req req, logic [15:0] h = '0,
                                logic [31:0] d = '0, logic [31:0] p = '0,
                                logic [7:0] sid = '0);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            if ($urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        s_axis_tdata <= {6'b0, sid, p, d, h, req};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(req, h, d, p, sid);
    endtask

    task automatic wait_drained;
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (2 * dlts_pkg::NUM_SLOTS + 20) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 1;
        if (long_hold > 0) begin
            m_axis_tready <= 1'b0;
            long_hold <= long_hold - 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 15) < 3 && ready_phase[7:6] != 2'b11)
                ? 1'b0 : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected transaction status", m_axis_tdata[2:0], -1);
            end else begin
                want = due_results.pop_front();
                if (m_axis_tdata[2:0] != want.status)
                    report_mismatch("status", m_axis_tdata[2:0], want.status);
                if (m_axis_tdata[6:3] != want.slot)
                    report_mismatch("slot", m_axis_tdata[6:3], want.slot);
                if (m_axis_tdata[22:7] != want.handle)
                    report_mismatch("handle", m_axis_tdata[22:7], want.handle);
                if (m_axis_tdata[23] != 1'b0)
                    report_mismatch("fill bit", m_axis_tdata[23], 0);
                if (m_axis_tlast != want.last)
                    report_mismatch("last", m_axis_tlast, want.last);
            end
        end
    end

    task automatic test_empty_list;
        send_request(dlts_pkg::REQ_TICK);
        send_request(dlts_pkg::REQ_DISP);
        send_request(dlts_pkg::REQ_DEL, 16'hFFFF, '1, '1, 8'd0);
        send_request(dlts_pkg::REQ_DEL, '0, '0, '0, 8'hFF);
    endtask

    task automatic test_fill_and_extremes;
        send_request(dlts_pkg::REQ_ADD, 16'h0000, 32'd0, 32'd0);
        send_request(dlts_pkg::REQ_ADD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(dlts_pkg::REQ_ADD, 16'hA5A5, 32'd0, 32'd3);
        send_request(dlts_pkg::REQ_ADD, 16'h5A5A, 32'd2, 32'd0);
        send_request(dlts_pkg::REQ_ADD, 16'h1234, 32'd2, 32'd1);
        for (int i = 0; i < 12; i++)
            send_request(dlts_pkg::REQ_ADD, 16'(i), 32'(i % 3), 32'(i % 2));
        send_request(dlts_pkg::REQ_DEL, '0, '0, '0, 8'd4);
        send_request(dlts_pkg::REQ_DEL, '0, '0, '0, 8'd4);
        send_request(dlts_pkg::REQ_DEL, '0, '0, '0, 8'd20);
        send_request(dlts_pkg::REQ_DISP);
        send_request(dlts_pkg::REQ_TICK);
        send_request(dlts_pkg::REQ_DISP);
        send_request(dlts_pkg::REQ_TICK);
        send_request(dlts_pkg::REQ_DISP);
    endtask

    task automatic test_backpressure;
        long_hold = 300;
        for (int i = 0; i < 10; i++)
            send_request(dlts_pkg::REQ_ADD, 16'($urandom), 32'(i), 32'(i & 1));
        send_request(dlts_pkg::REQ_DISP);
    endtask

    task automatic test_random_traffic(int n);
        int c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 9);
            if (c < 3)
                send_request(dlts_pkg::REQ_TICK);
            else if (c < 6)
                send_request(dlts_pkg::REQ_ADD, 16'($urandom),
                    $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 5)),
                    $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 4)));
            else if (c < 7)
                send_request(dlts_pkg::REQ_DEL, 16'($urandom), $urandom, $urandom,
                    $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 15)));
            else
                send_request(dlts_pkg::REQ_DISP, 16'($urandom), $urandom, $urandom,
                    8'($urandom));
        end
    endtask

    initial begin
        head_q = dlts_pkg::NUM_SLOTS;
        for (int i = 0; i < dlts_pkg::NUM_SLOTS; i++) free_slot(i);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_fill_and_extremes();
        test_backpressure();
        test_random_traffic(170);
        wait_drained();
        if (n_errors == 0 && due_results.size() == 0)
            $display("PASS delta_list_timer_scheduler");
        else
            $display("FAIL delta_list_timer_scheduler");
        $finish;
    end

    initial begin
        #4ms;
        $display("FAIL delta_list_timer_scheduler");
        $finish;
    end
endmodule
`default_nettype wire
